// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

  // Command codes carried with a tick
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Phase value meaning "this command has no bit loop"
  localparam logic [2:0] NO_LOOP = 3'd7;

  // Last bit of a byte, counted from zero
  localparam logic [2:0] LAST_BIT = 3'd7;

  // What a sequence step does on the tick it is entered
  typedef enum logic [3:0] {
    ACT_SCL0       = 4'd0,
    ACT_SCL1       = 4'd1,
    ACT_SDA0       = 4'd2,
    ACT_SDA1       = 4'd3,
    ACT_SDA_DATA   = 4'd4,
    ACT_SCL0_SHIFT = 4'd5,
    ACT_SAMPLE_ACK = 4'd6,
    ACT_SAMPLE_BIT = 4'd7,
    ACT_SDA_ACK    = 4'd8
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [2:0] hold;
  } step_t;

  function automatic step_t step_lookup(input logic [1:0] op, input logic [2:0] phase);
    step_t s;
    s = '{act: ACT_SCL0, hold: 3'd1};
    unique case (op)
      OP_START: begin
        case (phase)
          3'd0: s = '{act: ACT_SCL1, hold: 3'd3};
          3'd1: s = '{act: ACT_SDA1, hold: 3'd3};
          3'd2: s = '{act: ACT_SDA0, hold: 3'd3};
          3'd3: s = '{act: ACT_SCL0, hold: 3'd3};
          default: s = '{act: ACT_SCL0, hold: 3'd1};
        endcase
      end
      OP_STOP: begin
        case (phase)
          3'd0: s = '{act: ACT_SDA0, hold: 3'd3};
          3'd1: s = '{act: ACT_SCL1, hold: 3'd3};
          3'd2: s = '{act: ACT_SDA1, hold: 3'd3};
          default: s = '{act: ACT_SCL0, hold: 3'd1};
        endcase
      end
      OP_WRITE: begin
        case (phase)
          3'd0: s = '{act: ACT_SDA_DATA,   hold: 3'd3};
          3'd1: s = '{act: ACT_SCL1,       hold: 3'd5};
          3'd2: s = '{act: ACT_SCL0_SHIFT, hold: 3'd2};
          3'd3: s = '{act: ACT_SDA1,       hold: 3'd3};
          3'd4: s = '{act: ACT_SCL1,       hold: 3'd3};
          3'd5: s = '{act: ACT_SAMPLE_ACK, hold: 3'd2};
          3'd6: s = '{act: ACT_SCL0,       hold: 3'd5};
          default: s = '{act: ACT_SCL0, hold: 3'd1};
        endcase
      end
      OP_READ: begin
        case (phase)
          3'd0: s = '{act: ACT_SDA1,       hold: 3'd3};
          3'd1: s = '{act: ACT_SCL1,       hold: 3'd3};
          3'd2: s = '{act: ACT_SAMPLE_BIT, hold: 3'd2};
          3'd3: s = '{act: ACT_SCL0,       hold: 3'd5};
          3'd4: s = '{act: ACT_SDA_ACK,    hold: 3'd3};
          3'd5: s = '{act: ACT_SCL1,       hold: 3'd5};
          3'd6: s = '{act: ACT_SCL0,       hold: 3'd5};
          default: s = '{act: ACT_SCL0, hold: 3'd1};
        endcase
      end
      default: s = '{act: ACT_SCL0, hold: 3'd1};
    endcase
    return s;
  endfunction

  function automatic logic [3:0] step_count(input logic [1:0] op);
    logic [3:0] n;
    unique case (op)
      OP_START: n = 4'd4;
      OP_STOP:  n = 4'd3;
      OP_WRITE: n = 4'd7;
      OP_READ:  n = 4'd7;
      default:  n = 4'd7;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] loop_start(input logic [1:0] op);
    logic [2:0] p;
    unique case (op)
      OP_WRITE: p = 3'd0;
      OP_READ:  p = 3'd1;
      default:  p = NO_LOOP;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] loop_end(input logic [1:0] op);
    logic [2:0] p;
    unique case (op)
      OP_WRITE: p = 3'd2;
      OP_READ:  p = 3'd3;
      default:  p = NO_LOOP;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps

// Open-drain I2C master byte engine paced by one-microsecond ticks. Every transfer on the
// input stream is one tick: it carries the sampled SDA level and, when the command flag is
// set, a start, stop, write-byte or read-byte command. A command runs as a fixed list of
// steps, each of which changes one pin or samples SDA and then holds for three, five or two
// ticks; writes shift the byte out MSB first and sample the slave's acknowledge, reads shift
// eight bits in and then drive acknowledge or not-acknowledge. Every tick yields exactly one
// result transfer with both pin levels, busy, a done pulse, and on the done tick the read
// byte or the acknowledge status. Commands that arrive while a command is running, its done
// tick included, are ignored. The engine takes one tick per clock cycle: the whole step
// sequencer update sits between the state registers and one output register, so a new tick
// is taken on every cycle in which the output register is empty or being emptied.
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] write_byte, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [15:0] s_axis_tdata,
  // [0] cmd_valid, [2:1] operation
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_seen, [15:13] zero
  output logic [15:0] m_axis_tdata
);

  // Input fields
  logic       cmd_valid;
  logic [1:0] operation;
  logic [7:0] write_byte;
  logic       send_ack;
  logic       sda_in;

  assign cmd_valid  = s_axis_tuser[0];
  assign operation  = s_axis_tuser[2:1];
  assign write_byte = s_axis_tdata[7:0];
  assign send_ack   = s_axis_tdata[8];
  assign sda_in     = s_axis_tdata[9];

  // Sequencer state
  logic       in_progress, in_progress_next;
  logic [1:0] active_op, active_op_next;
  logic [2:0] bit_index, bit_index_next;
  logic [2:0] sub_phase, sub_phase_next;
  logic [2:0] hold_count, hold_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic       ack_choice, ack_choice_next;
  logic       ack_flag, ack_flag_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;

  // Result of this tick
  logic       busy_res, done_res, ack_seen;
  logic [7:0] rx_byte;

  logic       step_en;
  step_t      step;
  logic       s_acc;

  // A tick is taken whenever the output register can take its result in the same edge.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_progress_next = in_progress;
    active_op_next   = active_op;
    bit_index_next   = bit_index;
    sub_phase_next   = sub_phase;
    hold_count_next  = hold_count;
    shift_reg_next   = shift_reg;
    ack_choice_next  = ack_choice;
    ack_flag_next    = ack_flag;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    busy_res         = 1'b0;
    done_res         = 1'b0;
    rx_byte          = '0;
    ack_seen         = 1'b0;
    step_en          = 1'b0;

    if (in_progress) begin
      busy_res = 1'b1;
      if (hold_count != 3'd0) begin
        hold_count_next = hold_count - 3'd1;
      end else begin
        step_en = 1'b1;
        // At the end of a bit, go round the bit loop until all eight bits are through.
        if (sub_phase == loop_end(active_op) && bit_index != LAST_BIT) begin
          bit_index_next = bit_index + 3'd1;
          sub_phase_next = loop_start(active_op);
        end else begin
          sub_phase_next = sub_phase + 3'd1;
        end
      end
    end else if (cmd_valid) begin
      busy_res         = 1'b1;
      in_progress_next = 1'b1;
      active_op_next   = operation;
      sub_phase_next   = '0;
      bit_index_next   = '0;
      ack_flag_next    = 1'b0;
      ack_choice_next  = send_ack;
      shift_reg_next   = (operation == OP_WRITE) ? write_byte : 8'h00;
      step_en          = 1'b1;
    end

    step = step_lookup(active_op_next, sub_phase_next);
    if (step_en) begin
      unique case (step.act)
        ACT_SCL0:       scl_reg_next = 1'b0;
        ACT_SCL1:       scl_reg_next = 1'b1;
        ACT_SDA0:       sda_reg_next = 1'b0;
        ACT_SDA1:       sda_reg_next = 1'b1;
        ACT_SDA_DATA:   sda_reg_next = shift_reg_next[7];
        ACT_SCL0_SHIFT: begin
          scl_reg_next   = 1'b0;
          shift_reg_next = {shift_reg_next[6:0], 1'b0};
        end
        ACT_SAMPLE_ACK: ack_flag_next  = !sda_in;
        ACT_SAMPLE_BIT: shift_reg_next = {shift_reg_next[6:0], sda_in};
        ACT_SDA_ACK:    sda_reg_next   = !ack_choice_next;
        default:        scl_reg_next   = scl_reg_next;
      endcase
      hold_count_next = step.hold - 3'd1;
    end

    // The command ends once its last step has served its hold.
    if (in_progress_next && hold_count_next == 3'd0 &&
        ({1'b0, sub_phase_next} + 4'd1) >= step_count(active_op_next)) begin
      in_progress_next = 1'b0;
      done_res         = 1'b1;
      if (active_op_next == OP_READ) begin
        rx_byte = shift_reg_next;
      end
      if (active_op_next == OP_WRITE) begin
        ack_seen = ack_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress <= 1'b0;
      active_op   <= '0;
      bit_index   <= '0;
      sub_phase   <= '0;
      hold_count  <= '0;
      shift_reg   <= '0;
      ack_choice  <= 1'b0;
      ack_flag    <= 1'b0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
    end else if (s_acc) begin
      in_progress <= in_progress_next;
      active_op   <= active_op_next;
      bit_index   <= bit_index_next;
      sub_phase   <= sub_phase_next;
      hold_count  <= hold_count_next;
      shift_reg   <= shift_reg_next;
      ack_choice  <= ack_choice_next;
      ack_flag    <= ack_flag_next;
      scl_reg     <= scl_reg_next;
      sda_reg     <= sda_reg_next;
    end
  end

  // Output register: one result transfer for each tick taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      m_axis_tdata <= {3'b000, ack_seen, rx_byte, done_res, busy_res,
                       sda_reg_next, scl_reg_next};
    end
  end

  // An idle engine never has a hold pending.
  assert property (@(posedge clk) disable iff (rst)
    !in_progress |-> hold_count == 3'd0)
    else $error("hold count left over while idle");

  // While a hold runs down, the sequence position stays put.
  assert property (@(posedge clk) disable iff (rst)
    (s_acc && in_progress && hold_count != 3'd0) |=>
      (sub_phase == $past(sub_phase) && bit_index == $past(bit_index)))
    else $error("sequence moved during a hold");

  // A running command never steps past its own list.
  assert property (@(posedge clk) disable iff (rst)
    in_progress |-> ({1'b0, sub_phase} < step_count(active_op)))
    else $error("step index beyond the command's step list");

  // A done pulse frees the engine for the next command.
  assert property (@(posedge clk) disable iff (rst)
    (s_acc && done_res) |=> !in_progress)
    else $error("engine still busy after done");

endmodule

// ===== verif/i2c_master_byte_engine_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the I2C master byte engine. Every input transfer is one tick;
// every tick yields exactly one result transfer, so the bench keeps a tick-accurate
// model of the step sequencer and queues one expected pin/status word per accepted tick.
module i2c_master_byte_engine_tb
  import i2cm_pkg::*;
;

  // One result transfer, laid out exactly as m_axis_tdata[12:0].
  typedef struct packed {
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } line_state_t;

  // One accepted tick as the engine saw it.
  typedef struct {
    logic       cmd;
    logic [1:0] op;
    logic [7:0] wbyte;
    logic       ack;
    logic       sda_in;
  } tick_t;

  // Model of the sequencer plus the queue of pin/status words it predicts.
  class tick_scoreboard;
    line_state_t line_q[$];
    int unsigned errors;

    step_t      plan [4][8];
    logic [2:0] loop_first [4];
    logic [2:0] loop_last [4];
    logic [3:0] steps_in [4];

    logic [1:0] op;
    logic       running;
    logic [3:0] bit_cnt;
    logic [2:0] phase;
    logic [2:0] hold;
    logic [7:0] shifter;
    logic       ack_want;
    logic       ack_got;
    logic       scl;
    logic       sda;

    function new();
      plan[OP_START] = '{'{ACT_SCL1, 3'd3}, '{ACT_SDA1, 3'd3}, '{ACT_SDA0, 3'd3},
                         '{ACT_SCL0, 3'd3}, '{ACT_SCL0, 3'd1}, '{ACT_SCL0, 3'd1},
                         '{ACT_SCL0, 3'd1}, '{ACT_SCL0, 3'd1}};
      plan[OP_STOP]  = '{'{ACT_SDA0, 3'd3}, '{ACT_SCL1, 3'd3}, '{ACT_SDA1, 3'd3},
                         '{ACT_SCL0, 3'd1}, '{ACT_SCL0, 3'd1}, '{ACT_SCL0, 3'd1},
                         '{ACT_SCL0, 3'd1}, '{ACT_SCL0, 3'd1}};
      plan[OP_WRITE] = '{'{ACT_SDA_DATA, 3'd3}, '{ACT_SCL1, 3'd5},
                         '{ACT_SCL0_SHIFT, 3'd2}, '{ACT_SDA1, 3'd3}, '{ACT_SCL1, 3'd3},
                         '{ACT_SAMPLE_ACK, 3'd2}, '{ACT_SCL0, 3'd5}, '{ACT_SCL0, 3'd1}};
      plan[OP_READ]  = '{'{ACT_SDA1, 3'd3}, '{ACT_SCL1, 3'd3}, '{ACT_SAMPLE_BIT, 3'd2},
                         '{ACT_SCL0, 3'd5}, '{ACT_SDA_ACK, 3'd3}, '{ACT_SCL1, 3'd5},
                         '{ACT_SCL0, 3'd5}, '{ACT_SCL0, 3'd1}};
      loop_first = '{NO_LOOP, NO_LOOP, 3'd0, 3'd1};
      loop_last  = '{NO_LOOP, NO_LOOP, 3'd2, 3'd3};
      steps_in   = '{4'd4, 4'd3, 4'd7, 4'd7};
      op       = OP_START;
      running  = 1'b0;
      bit_cnt  = 4'd0;
      phase    = 3'd0;
      hold     = 3'd0;
      shifter  = 8'h00;
      ack_want = 1'b0;
      ack_got  = 1'b0;
      scl      = 1'b1;
      sda      = 1'b1;
      errors   = 0;
    endfunction

    // Apply the step that has just been entered, then load its hold.
    function void enter_step(logic sda_in);
      step_t s;
      s = plan[op][phase];
      case (s.act)
        ACT_SCL0:       scl = 1'b0;
        ACT_SCL1:       scl = 1'b1;
        ACT_SDA0:       sda = 1'b0;
        ACT_SDA1:       sda = 1'b1;
        ACT_SDA_DATA:   sda = shifter[7];
        ACT_SCL0_SHIFT: begin
          scl     = 1'b0;
          shifter = {shifter[6:0], 1'b0};
        end
        ACT_SAMPLE_ACK: ack_got = ~sda_in;
        ACT_SAMPLE_BIT: shifter = {shifter[6:0], sda_in};
        ACT_SDA_ACK:    sda = ~ack_want;
        default: ;
      endcase
      hold = s.hold - 3'd1;
    endfunction

    function void note_tick(tick_t t);
      line_state_t r;
      r = '0;
      if (running) begin
        r.busy = 1'b1;
        if (hold != 3'd0) begin
          hold = hold - 3'd1;
        end else begin
          if (phase == loop_last[op] && bit_cnt < {1'b0, LAST_BIT}) begin
            bit_cnt = bit_cnt + 4'd1;
            phase   = loop_first[op];
          end else begin
            phase = phase + 3'd1;
          end
          enter_step(t.sda_in);
        end
      end else if (t.cmd) begin
        r.busy   = 1'b1;
        running  = 1'b1;
        op       = t.op;
        phase    = 3'd0;
        bit_cnt  = 4'd0;
        ack_got  = 1'b0;
        ack_want = t.ack;
        shifter  = (t.op == OP_WRITE) ? t.wbyte : 8'h00;
        enter_step(t.sda_in);
      end
      if (running && hold == 3'd0 && ({1'b0, phase} + 4'd1) >= steps_in[op]) begin
        running = 1'b0;
        r.done  = 1'b1;
        if (op == OP_READ) r.rx_byte = shifter;
        if (op == OP_WRITE) r.ack_seen = ack_got;
      end
      r.scl = scl;
      r.sda = sda;
      line_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [15:0] word);
      line_state_t got, want;
      got = word[12:0];
      if (line_q.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived, expected none", $time, word);
        return;
      end
      want = line_q.pop_front();
      compare_field("scl_level", 8'(want.scl), 8'(got.scl));
      compare_field("sda_level", 8'(want.sda), 8'(got.sda));
      compare_field("busy_res", 8'(want.busy), 8'(got.busy));
      compare_field("done_res", 8'(want.done), 8'(got.done));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  // [7:0] write_byte, [8] send_ack, [9] sda_in, [15:10] zero
  logic [15:0] s_axis_tdata = '0;
  // [0] cmd_valid, [2:1] operation
  logic [2:0]  s_axis_tuser = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_seen, [15:13] zero
  wire  [15:0] m_axis_tdata;

  tick_scoreboard sb = new();

  // Number of ticks accepted so far, and whether the sender is in a gap-free stretch.
  int unsigned ticks_sent = 0;
  bit          sender_calm = 1'b0;

  i2c_master_byte_engine dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Offers one tick after a random gap and waits for its transfer. The valid is only
  // lowered when a gap is actually taken, so back-to-back ticks keep it high throughout.
  task automatic drive_tick(input logic cmd, input logic [1:0] op, input logic [7:0] wbyte,
                            input logic ack, input logic sda_in);
    int unsigned gap;
    tick_t t;
    gap = sender_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, sda_in, ack, wbyte};
    s_axis_tuser  <= {op, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    t = '{cmd, op, wbyte, ack, sda_in};
    sb.note_tick(t);
    ticks_sent++;
  endtask

  // Idle ticks carry random rubbish in the fields that only matter with a command.
  task automatic idle_ticks(input int unsigned n);
    repeat (n) begin
      drive_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Issues a command on an idle engine and keeps ticking until the model reports it done.
  // The SDA level seen by the engine is held low, held high, or random (sda_mode 0, 1, 2).
  // While the command runs, stray commands turn up with the given percentage; the engine
  // must ignore them, the done tick included.
  task automatic run_command(input logic [1:0] op, input logic [7:0] wbyte, input logic ack,
                             input int sda_mode, input int unsigned stray_pct);
    logic s;
    s = (sda_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(sda_mode);
    drive_tick(1'b1, op, wbyte, ack, s);
    while (sb.running) begin
      s = (sda_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(sda_mode);
      drive_tick(1'($urandom_range(0, 99) < stray_pct), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s);
    end
  endtask

  initial begin
    int unsigned target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Idle ticks with both SDA levels, then a start with a command offered
    // on every one of its ticks, done tick included.
    drive_tick(1'b0, OP_READ, 8'hFF, 1'b1, 1'b0);
    drive_tick(1'b0, OP_READ, 8'hFF, 1'b1, 1'b1);
    run_command(OP_START, 8'h00, 1'b0, 2, 100);
    // All-ones byte with the slave acknowledging, all-zeros byte with no acknowledge.
    run_command(OP_WRITE, 8'hFF, 1'b0, 0, 0);
    run_command(OP_WRITE, 8'h00, 1'b1, 1, 0);
    // Reads of a line held high (acknowledge driven) and held low (not-acknowledge).
    run_command(OP_READ, 8'h00, 1'b1, 1, 0);
    run_command(OP_READ, 8'hFF, 1'b0, 0, 0);
    // A write straight after the previous done tick, then a stop with stray commands.
    run_command(OP_WRITE, 8'hA5, 1'b0, 2, 0);
    run_command(OP_STOP, 8'h5A, 1'b1, 2, 50);
    idle_ticks(2);

    // Random part: mostly proper transactions (start, one to three bytes, stop) with
    // random content, the rest loose commands in any order.
    target = 1050;
    while (ticks_sent < target) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        run_command(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 0);
        repeat ($urandom_range(1, 3)) begin
          idle_ticks($urandom_range(0, 2));
          run_command($urandom_range(0, 1) ? OP_WRITE : OP_READ, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 2, $urandom_range(0, 1) ? 0 : 6);
        end
        run_command(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 0);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          run_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 2, 10);
        end
      end
      idle_ticks($urandom_range(0, 3));
    end
    s_axis_tvalid <= 1'b0;

    // Let every outstanding result drain, then allow for the single output register.
    while (sb.line_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("i2c_master_byte_engine_tb: PASS");
    end else begin
      $display("i2c_master_byte_engine_tb: FAIL");
    end
    $finish;
  end

  // Result side: a random stall before each transfer, with occasional gap-free stretches,
  // and every accepted result is checked against the oldest prediction.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata);
      taken++;
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("i2c_master_byte_engine_tb: FAIL");
    $finish;
  end

endmodule
